FILE: src/bounded_positional_list_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded positional list
// Short forms for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_POSITIONAL_LIST_MACROS_SVH
`define BOUNDED_POSITIONAL_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded_positional_list check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_positional_list check failed");

`endif

FILE: src/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg
// Types, command codes and sizing constants of the bounded positional list.
// ----------------------------------------------------------------------------
`default_nettype none

package bpl_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned CAPACITY_MAX = 64;
    localparam int unsigned IDX_MAX_W    = $clog2(CAPACITY_MAX);

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_POS   = 3'd2;
    localparam logic [2:0] CMD_REM_FRONT = 3'd3;
    localparam logic [2:0] CMD_REM_BACK  = 3'd4;
    localparam logic [2:0] CMD_REM_POS   = 3'd5;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
        logic [4:0]         position;
    } bpl_cmd_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic               removed_valid;
        logic               overflow;
        logic               out_of_bound;
        logic [4:0]         item_count;
    } bpl_result_t;

    // Broadcast to every cell: what the row does this cycle and where.
    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic [IDX_MAX_W-1:0] idx;
    } bpl_cell_ctl_t;

    typedef struct packed {
        logic       removed_valid;
        logic       overflow;
        logic       out_of_bound;
        logic [4:0] item_count;
    } bpl_status_t;

endpackage

`default_nettype wire

FILE: src/bounded_positional_list.sv
// ----------------------------------------------------------------------------
// bounded_positional_list
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// A request is taken at any rising edge with start high; busy never rises, so
// one command completes every clock cycle. The whole row of cells shifts left
// or right at once, which sets the rate. The result appears in the cycle
// after the request, on result, with done high for exactly one cycle;
// the receiver cannot stall it, so it must take every result as it comes.
// The list starts empty after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_positional_list #(
    parameter int unsigned CAPACITY = bpl_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bpl_pkg::bpl_cmd_t request,
    output logic                   done,
    output bpl_pkg::bpl_result_t   result
);

    logic                   accept;
    bpl_pkg::bpl_cell_ctl_t ctl;
    bpl_pkg::bpl_status_t   status;
    logic signed [31:0]     cell_q   [CAPACITY];
    logic signed [31:0]     cell_tap [CAPACITY];
    logic signed [31:0]     removed;
    logic                   done_reg;
    bpl_pkg::bpl_result_t   result_reg;
    bpl_pkg::bpl_result_t   result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    bpl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .ctl     (ctl),
        .status  (status)
    );

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [31:0] left_in;
        logic signed [31:0] right_in;

        if (k == 0)
        begin : g_first
            assign left_in = 32'sd0;
        end
        else
        begin : g_mid_l
            assign left_in = cell_q[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_q[k];
        end
        else
        begin : g_mid_r
            assign right_in = cell_q[k+1];
        end

        bpl_cell #(
            .INDEX (k)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .value (request.value),
            .left  (left_in),
            .right (right_in),
            .q     (cell_q[k]),
            .tap   (cell_tap[k])
        );
    end

    // Only the selected cell drives its tap, so OR the taps together.
    always_comb
    begin
        removed = 32'sd0;
        for (int unsigned i = 0; i < CAPACITY; i++)
        begin
            removed = removed | cell_tap[i];
        end
    end

    always_comb
    begin
        result_next.removed_value = removed;
        result_next.removed_valid = status.removed_valid;
        result_next.overflow      = status.overflow;
        result_next.out_of_bound  = status.out_of_bound;
        result_next.item_count    = status.item_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: src/bpl_cell.sv
// ----------------------------------------------------------------------------
// bpl_cell
// One list slot: holds, loads the new value, or takes a neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module bpl_cell #(
    parameter int unsigned INDEX = 0
) (
    input  wire logic                  clk,
    input  wire bpl_pkg::bpl_cell_ctl_t ctl,
    input  wire logic signed [31:0]    value,
    input  wire logic signed [31:0]    left,
    input  wire logic signed [31:0]    right,
    output logic signed [31:0]         q,
    output logic signed [31:0]         tap
);

    localparam logic [bpl_pkg::IDX_MAX_W-1:0] MY_IDX = bpl_pkg::IDX_MAX_W'(INDEX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (ctl.ins && (MY_IDX > ctl.idx))
        begin
            data_next = left;
        end
        else if (ctl.ins && (MY_IDX == ctl.idx))
        begin
            data_next = value;
        end
        else if (ctl.rem && (MY_IDX >= ctl.idx))
        begin
            data_next = right;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q   = data_reg;
    // Drive the removed value onto the shared OR bus only from the selected slot.
    assign tap = (ctl.rem && (MY_IDX == ctl.idx)) ? data_reg : 32'sd0;

endmodule

`default_nettype wire

FILE: src/bpl_ctrl.sv
// ----------------------------------------------------------------------------
// bpl_ctrl
// Command decode and element count: picks the slot and the row operation.
// ----------------------------------------------------------------------------
`default_nettype none

module bpl_ctrl #(
    parameter int unsigned CAPACITY = bpl_pkg::CAPACITY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire bpl_pkg::bpl_cmd_t  request,
    output bpl_pkg::bpl_cell_ctl_t  ctl,
    output bpl_pkg::bpl_status_t    status
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned WW = ((CW > 5) ? CW : 5) + 1;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [4:0]    pos_eff;
    logic [WW-1:0] cnt_w;
    logic [WW-1:0] pos_w;
    logic [WW-1:0] idx_w;
    logic          full;
    logic          ins;
    logic          rem;
    logic          ovf;
    logic          oob;
    logic          rvalid;

    assign pos_eff = (request.position == 5'd0) ? 5'd1 : request.position;
    assign cnt_w   = WW'(count_reg);
    assign pos_w   = WW'(pos_eff);
    assign full    = (count_reg >= CW'(CAPACITY));

    always_comb
    begin
        ins        = 1'b0;
        rem        = 1'b0;
        ovf        = 1'b0;
        oob        = 1'b0;
        rvalid     = 1'b0;
        idx_w      = '0;
        count_next = count_reg;
        unique case (request.cmd)
            bpl_pkg::CMD_INS_FRONT, bpl_pkg::CMD_INS_BACK, bpl_pkg::CMD_INS_POS:
            begin
                if (full)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    ins        = 1'b1;
                    count_next = count_reg + CW'(1);
                    priority if (request.cmd == bpl_pkg::CMD_INS_FRONT)
                    begin
                        idx_w = '0;
                    end
                    else if (request.cmd == bpl_pkg::CMD_INS_BACK)
                    begin
                        idx_w = cnt_w;
                    end
                    else if (pos_w > (cnt_w + WW'(1)))
                    begin
                        // append when the position lies past the end
                        oob   = 1'b1;
                        idx_w = cnt_w;
                    end
                    else
                    begin
                        idx_w = pos_w - WW'(1);
                    end
                end
            end
            bpl_pkg::CMD_REM_FRONT, bpl_pkg::CMD_REM_BACK, bpl_pkg::CMD_REM_POS:
            begin
                if (count_reg != '0)
                begin
                    priority if (request.cmd == bpl_pkg::CMD_REM_FRONT)
                    begin
                        rem   = 1'b1;
                        idx_w = '0;
                    end
                    else if (request.cmd == bpl_pkg::CMD_REM_BACK)
                    begin
                        rem   = 1'b1;
                        idx_w = cnt_w - WW'(1);
                    end
                    else if (pos_w > cnt_w)
                    begin
                        oob = 1'b1;
                    end
                    else
                    begin
                        rem   = 1'b1;
                        idx_w = pos_w - WW'(1);
                    end
                    if (rem)
                    begin
                        rvalid     = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    assign ctl.ins = accept && ins;
    assign ctl.rem = accept && rem;
    assign ctl.idx = bpl_pkg::IDX_MAX_W'(idx_w);

    assign status.removed_valid = rvalid;
    assign status.overflow      = ovf;
    assign status.out_of_bound  = oob;
    assign status.item_count    = 5'(count_next);

endmodule

`default_nettype wire

FILE: src/bpl_checker.sv
// ----------------------------------------------------------------------------
// bpl_checker
// Port-level checks of request/result timing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_positional_list_macros.svh"

module bpl_checker #(
    parameter int unsigned CAPACITY = bpl_pkg::CAPACITY_DEF
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire bpl_pkg::bpl_result_t result
);

    localparam logic [4:0] FULL_COUNT = 5'(CAPACITY);

    // every accepted request yields exactly one result in the next cycle
    `BPL_ASSERT_NXT(a_result_follows, start && !busy, done)
    `BPL_ASSERT_NXT(a_no_stray_result, !(start && !busy), !done)
    // a rejected insert leaves the list full and removes nothing
    `BPL_ASSERT_IMP(a_overflow_full, done && result.overflow,
        (result.item_count == FULL_COUNT) && !result.removed_valid)
    `BPL_ASSERT_IMP(a_value_zero, done && !result.removed_valid,
        result.removed_value == 32'sd0)

endmodule

bind bounded_positional_list bpl_checker #(
    .CAPACITY (CAPACITY)
) u_bpl_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

`default_nettype wire

FILE: bench/bpl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_scoreboard
// Watches the request and result channels of the bounded positional list,
// keeps its own copy of the list, and compares each result field by field.
// ----------------------------------------------------------------------------

module bpl_scoreboard #(
    parameter int unsigned CAPACITY = bpl_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  bpl_pkg::bpl_cmd_t    request,
    input  logic                 done,
    input  bpl_pkg::bpl_result_t result,
    output int                   mismatches,
    output int                   outstanding
);

    logic signed [31:0]   list_cells [CAPACITY];
    int                   list_len;
    bpl_pkg::bpl_result_t pending_results [$];
    int                   fail_total = 0;

    assign mismatches = fail_total;

    // Apply one request to the local list and return the result it must give.
    function automatic bpl_pkg::bpl_result_t apply_request(input bpl_pkg::bpl_cmd_t req);
        bpl_pkg::bpl_result_t res;
        int                   pos;
        int                   slot;
        bit                   take;
        res  = '0;
        pos  = (req.position == 0) ? 1 : int'(req.position);
        slot = 0;
        take = 1'b0;
        case (req.cmd)
            bpl_pkg::CMD_INS_FRONT, bpl_pkg::CMD_INS_BACK, bpl_pkg::CMD_INS_POS:
            begin
                if (list_len >= CAPACITY)
                begin
                    res.overflow = 1'b1;
                end
                else
                begin
                    if (req.cmd == bpl_pkg::CMD_INS_FRONT)
                        slot = 0;
                    else if (req.cmd == bpl_pkg::CMD_INS_BACK)
                        slot = list_len;
                    else if (pos > list_len + 1)
                    begin
                        // past the end: append and flag it
                        res.out_of_bound = 1'b1;
                        slot = list_len;
                    end
                    else
                        slot = pos - 1;
                    for (int k = list_len; k > slot; k--)
                        list_cells[k] = list_cells[k-1];
                    list_cells[slot] = req.value;
                    list_len++;
                end
            end
            bpl_pkg::CMD_REM_FRONT, bpl_pkg::CMD_REM_BACK, bpl_pkg::CMD_REM_POS:
            begin
                if (list_len != 0)
                begin
                    take = 1'b1;
                    if (req.cmd == bpl_pkg::CMD_REM_FRONT)
                        slot = 0;
                    else if (req.cmd == bpl_pkg::CMD_REM_BACK)
                        slot = list_len - 1;
                    else if (pos > list_len)
                    begin
                        res.out_of_bound = 1'b1;
                        take = 1'b0;
                    end
                    else
                        slot = pos - 1;
                    if (take)
                    begin
                        res.removed_value = list_cells[slot];
                        res.removed_valid = 1'b1;
                        for (int k = slot; k + 1 < list_len; k++)
                            list_cells[k] = list_cells[k+1];
                        list_len--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.item_count = list_len[4:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic signed [32:0] want,
                                        input logic signed [32:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bpl_pkg::bpl_result_t want;
        if (!rst_n)
        begin
            list_len = 0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // Compare first: a result at this edge belongs to an earlier request.
            if (done === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_total++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("removed_value", $signed(want.removed_value),
                                $signed(result.removed_value));
                    check_field("removed_valid", {32'd0, want.removed_valid},
                                {32'd0, result.removed_valid});
                    check_field("overflow", {32'd0, want.overflow}, {32'd0, result.overflow});
                    check_field("out_of_bound", {32'd0, want.out_of_bound},
                                {32'd0, result.out_of_bound});
                    check_field("item_count", {28'd0, want.item_count},
                                {28'd0, result.item_count});
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                pending_results.push_back(apply_request(request));
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random list commands into the bounded positional list
// with random gaps, and reports the scoreboard's verdict at the end of the run.
// ----------------------------------------------------------------------------

module tb_top;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int         RANDOM_ITEMS  = 520;

    logic                 clk;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    bpl_pkg::bpl_cmd_t    request = '0;
    logic                 busy;
    logic                 done;
    bpl_pkg::bpl_result_t result;
    int                   mismatches;
    int                   outstanding;
    int                   requests_sent = 0;
    bit                   no_gaps = 1'b0;

    bounded_positional_list dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    bpl_scoreboard u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Hold start high into the next request when there is no gap.
    task automatic issue_request(input logic [2:0] op, input logic signed [31:0] val,
                                 input logic [4:0] pos);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        request.cmd      <= op;
        request.value    <= val;
        request.position <= pos;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] pick_position();
        if ($urandom_range(0, 3) != 0)
            return 5'($urandom_range(0, bpl_pkg::CAPACITY_DEF + 1));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [2:0] pick_op(input int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            return 3'($urandom_range(bpl_pkg::CMD_INS_FRONT, bpl_pkg::CMD_INS_POS));
        if (r < 96)
            return 3'($urandom_range(bpl_pkg::CMD_REM_FRONT, bpl_pkg::CMD_REM_POS));
        return 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    endfunction

    initial
    begin
        int insert_pct;
        int run_len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: removals take nothing, unused codes do nothing
        issue_request(bpl_pkg::CMD_REM_FRONT, 32'sd5, 5'd0);
        issue_request(bpl_pkg::CMD_REM_BACK, 32'sd5, 5'd1);
        issue_request(bpl_pkg::CMD_REM_POS, 32'sd5, 5'd31);
        issue_request(CMD_UNUSED_LO, 32'sd9, 5'd3);
        issue_request(CMD_UNUSED_HI, -32'sd1, 5'd31);
        // position 0 and 1 both go to the front, once
        issue_request(bpl_pkg::CMD_INS_POS, 32'sh7fffffff, 5'd0);
        issue_request(bpl_pkg::CMD_INS_POS, 32'sh80000000, 5'd1);
        issue_request(bpl_pkg::CMD_INS_POS, 32'sd0, 5'd31);
        issue_request(bpl_pkg::CMD_INS_FRONT, -32'sd1, 5'd0);
        issue_request(bpl_pkg::CMD_INS_BACK, 32'sd10, 5'd31);
        issue_request(bpl_pkg::CMD_INS_POS, 32'sh5a5a5a5a, 5'd3);
        issue_request(bpl_pkg::CMD_REM_POS, 32'sd0, 5'd31);
        issue_request(bpl_pkg::CMD_REM_POS, 32'sd0, 5'd0);
        issue_request(bpl_pkg::CMD_REM_POS, 32'sd0, 5'd3);
        issue_request(bpl_pkg::CMD_REM_FRONT, 32'sd0, 5'd0);
        issue_request(bpl_pkg::CMD_REM_BACK, 32'sd0, 5'd0);
        wait_all_results();

        // Alternate fill, drain and mixed runs so full and empty both recur.
        while (requests_sent < RANDOM_ITEMS + 16)
        begin
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 12;
                default: insert_pct = 48;
            endcase
            run_len = $urandom_range(24, 32);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (run_len)
                issue_request(pick_op(insert_pct), pick_value(), pick_position());
            no_gaps = 1'b0;
            if ($urandom_range(0, 3) == 0)
                wait_all_results();
        end

        wait_all_results();
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
